// ===== src/m3i_pkg.sv =====
package m3i_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // product and cofactor widths
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int COF_W  = PROD_W + 1;
  // cofactor split for the determinant products
  localparam int LO_W   = WORD_BITS + 1;
  localparam int HI_W   = COF_W - LO_W;
  localparam int DET_W  = WORD_BITS + COF_W + 2;

  // numerator shift: 2*FRAC_BITS, plus one for the rounding half step
  localparam int SH     = 2 * FRAC_BITS + 1;
  // quotient bits kept; anything larger saturates
  localparam int QB     = WORD_BITS + 1;
  localparam int NUM_W  = DET_W + SH + QB;

  localparam int DET_LAT  = 4;
  localparam int LANE_LAT = QB + 2;
  localparam int LAT      = DET_LAT + LANE_LAT;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] a00;
    logic signed [WORD_BITS-1:0] a01;
    logic signed [WORD_BITS-1:0] a02;
    logic signed [WORD_BITS-1:0] a10;
    logic signed [WORD_BITS-1:0] a11;
    logic signed [WORD_BITS-1:0] a12;
    logic signed [WORD_BITS-1:0] a20;
    logic signed [WORD_BITS-1:0] a21;
    logic signed [WORD_BITS-1:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r00;
    logic signed [WORD_BITS-1:0] r01;
    logic signed [WORD_BITS-1:0] r02;
    logic signed [WORD_BITS-1:0] r10;
    logic signed [WORD_BITS-1:0] r11;
    logic signed [WORD_BITS-1:0] r12;
    logic signed [WORD_BITS-1:0] r20;
    logic signed [WORD_BITS-1:0] r21;
    logic signed [WORD_BITS-1:0] r22;
    logic                        singular;
  } inv_t;

endpackage

// ===== src/m3i_det.sv =====
module m3i_det import m3i_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  mat_t                    mat,
  output logic signed [COF_W-1:0] cof [9],
  output logic signed [DET_W-1:0] det
);

  // operand pairs of each cofactor: cof[i] = a[PA[2i]]*a[PB[2i]] - a[PA[2i+1]]*a[PB[2i+1]]
  localparam int PA [18] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
  localparam int PB [18] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};

  logic signed [WORD_BITS-1:0] a [9];
  logic signed [PROD_W-1:0]    prod [18];
  logic signed [WORD_BITS-1:0] row0_s1 [3];
  logic signed [WORD_BITS-1:0] row0_s2 [3];
  logic signed [COF_W-1:0]     cof_s2 [9];
  logic signed [COF_W-1:0]     cof_s3 [9];
  logic signed [COF_W-1:0]     cof_s4 [9];
  logic signed [LO_W+WORD_BITS:0]     lo_p [3];
  logic signed [HI_W+WORD_BITS-1:0]   hi_p [3];
  logic signed [DET_W-1:0]     det_s4;

  assign a[0] = mat.a00;
  assign a[1] = mat.a01;
  assign a[2] = mat.a02;
  assign a[3] = mat.a10;
  assign a[4] = mat.a11;
  assign a[5] = mat.a12;
  assign a[6] = mat.a20;
  assign a[7] = mat.a21;
  assign a[8] = mat.a22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 18; i++) begin
        prod[i] <= a[PA[i]] * a[PB[i]];
      end
      for (int k = 0; k < 3; k++) begin
        row0_s1[k] <= a[k];
        row0_s2[k] <= row0_s1[k];
      end
      for (int i = 0; i < 9; i++) begin
        cof_s2[i] <= COF_W'(prod[2*i]) - COF_W'(prod[2*i+1]);
        cof_s3[i] <= cof_s2[i];
        cof_s4[i] <= cof_s3[i];
      end
      // det = a00*cof0 + a01*cof3 + a02*cof6, cofactor split low/high
      for (int k = 0; k < 3; k++) begin
        lo_p[k] <= row0_s2[k] * $signed({1'b0, cof_s2[3*k][LO_W-1:0]});
        hi_p[k] <= row0_s2[k] * $signed(cof_s2[3*k][COF_W-1:LO_W]);
      end
      det_s4 <= (DET_W'(hi_p[0]) <<< LO_W) + DET_W'(lo_p[0])
              + (DET_W'(hi_p[1]) <<< LO_W) + DET_W'(lo_p[1])
              + (DET_W'(hi_p[2]) <<< LO_W) + DET_W'(lo_p[2]);
    end
  end

  assign cof = cof_s4;
  assign det = det_s4;

endmodule

// ===== src/m3i_lane.sv =====
module m3i_lane import m3i_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COF_W-1:0]     cof,
  input  logic signed [DET_W-1:0]     det,
  output logic signed [WORD_BITS-1:0] res
);

  localparam logic [QB-1:0] TOP_Q = QB'(1) << (WORD_BITS - 1);

  logic [COF_W-1:0] mag_c;
  logic [DET_W-1:0] mag_d;
  logic [NUM_W-1:0] rem [QB+1];
  logic [NUM_W-1:0] den [QB+1];
  logic [QB-1:0]    quo [QB+1];
  logic             neg [QB+1];
  logic             ovf [QB+1];
  logic [QB-1:0]    limit;
  logic [QB-1:0]    mag_q;
  logic signed [WORD_BITS-1:0] res_q;

  assign mag_c = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign mag_d = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

  // numerator 2|c|<<2F + |d|, divisor 2|d|: rounds half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (NUM_W'(mag_c) << SH) + NUM_W'(mag_d);
      den[0] <= NUM_W'(mag_d) << 1;
      quo[0] <= '0;
      neg[0] <= cof[COF_W-1] ^ det[DET_W-1];
      ovf[0] <= 1'b0;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int S = QB - 1 - k;
    logic [NUM_W-1:0] trial;
    logic             ge;
    assign trial = den[k] << S;
    assign ge    = rem[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - trial : rem[k];
        den[k+1] <= den[k];
        quo[k+1] <= {quo[k][QB-2:0], ge};
        neg[k+1] <= neg[k];
        if (k == 0) begin
          ovf[k+1] <= rem[k] >= (den[k] << QB);
        end else begin
          ovf[k+1] <= ovf[k];
        end
      end
    end
  end

  always_comb begin
    limit = neg[QB] ? TOP_Q : TOP_Q - QB'(1);
    mag_q = (ovf[QB] || quo[QB] > limit) ? limit : quo[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= neg[QB] ? -$signed(mag_q[WORD_BITS-1:0]) : $signed(mag_q[WORD_BITS-1:0]);
    end
  end

  assign res = res_q;

endmodule

// ===== src/matrix3x3_inverse.sv =====
// 3x3 matrix inverse, signed Q16.16, by adjugate over determinant. One matrix per
// transaction on mat, one inverse per transaction on inv, in order. The block takes
// a new matrix every cycle unless a result on inv is stalled. A matrix passes the
// cofactor and determinant stages, the nine division lanes (one restoring step per
// quotient bit, 33 bits) and the output register. Each element is rounded to
// nearest, ties away from zero, then saturated. A zero determinant gives all-zero
// elements with singular set. The whole pipeline holds only while a result on inv is stalled.
module matrix3x3_inverse import m3i_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  mat_t mat,
  output logic inv_valid,
  input  logic inv_stall,
  output inv_t inv
);

  logic                        adv;
  logic                        vld [LAT];
  logic                        sing [DET_LAT:LAT-1];
  logic signed [COF_W-1:0]     cof [9];
  logic signed [DET_W-1:0]     det;
  logic signed [WORD_BITS-1:0] res [9];
  logic                        inv_valid_q;
  inv_t                        inv_q;

  assign adv       = !(inv_valid_q && inv_stall);
  assign mat_stall = !adv;

  m3i_det u_det (
    .clk (clk),
    .en  (adv),
    .mat (mat),
    .cof (cof),
    .det (det)
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_lane u_lane (
      .clk (clk),
      .en  (adv),
      .cof (cof[i]),
      .det (det),
      .res (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
      inv_valid_q <= 1'b0;
    end else if (adv) begin
      vld[0] <= mat_valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
      inv_valid_q <= vld[LAT-1];
    end
  end

  // merge: singular flag travels beside the lanes and masks their results
  always_ff @(posedge clk) begin
    if (adv) begin
      sing[DET_LAT] <= det == '0;
      for (int i = DET_LAT + 1; i < LAT; i++) begin
        sing[i] <= sing[i-1];
      end
      inv_q.r00      <= sing[LAT-1] ? '0 : res[0];
      inv_q.r01      <= sing[LAT-1] ? '0 : res[1];
      inv_q.r02      <= sing[LAT-1] ? '0 : res[2];
      inv_q.r10      <= sing[LAT-1] ? '0 : res[3];
      inv_q.r11      <= sing[LAT-1] ? '0 : res[4];
      inv_q.r12      <= sing[LAT-1] ? '0 : res[5];
      inv_q.r20      <= sing[LAT-1] ? '0 : res[6];
      inv_q.r21      <= sing[LAT-1] ? '0 : res[7];
      inv_q.r22      <= sing[LAT-1] ? '0 : res[8];
      inv_q.singular <= sing[LAT-1];
    end
  end

  assign inv_valid = inv_valid_q;
  assign inv       = inv_q;

endmodule

// ===== src/m3i_checker.sv =====
module m3i_checker import m3i_pkg::*; (
  input logic clk,
  input logic rst,
  input logic mat_valid,
  input logic mat_stall,
  input mat_t mat,
  input logic inv_valid,
  input logic inv_stall,
  input inv_t inv
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !inv_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_stall |=> inv_valid && $stable(inv))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    mat_valid && mat_stall |=> mat_valid && $stable(mat))
    else $error("stalled matrix changed");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |->
      inv.r00 == '0 && inv.r01 == '0 && inv.r02 == '0 &&
      inv.r10 == '0 && inv.r11 == '0 && inv.r12 == '0 &&
      inv.r20 == '0 && inv.r21 == '0 && inv.r22 == '0)
    else $error("singular result with nonzero elements");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(inv_valid && inv_stall) |-> !mat_stall)
    else $error("input stalled while output is free");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
  .clk       (clk),
  .rst       (rst),
  .mat_valid (mat_valid),
  .mat_stall (mat_stall),
  .mat       (mat),
  .inv_valid (inv_valid),
  .inv_stall (inv_stall),
  .inv       (inv)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import m3i_pkg::*;

  localparam int N_RANDOM = 1200;
  localparam int ONE = 1 << FRAC_BITS;

  typedef logic signed [255:0] wide_t;

  logic clk;
  logic rst;
  logic mat_valid;
  logic mat_stall;
  mat_t mat;
  logic inv_valid;
  logic inv_stall;
  inv_t inv;

  mat_t mat_pending[$];
  inv_t inverse_due[$];
  logic mat_taken;
  int   mat_gap;
  int   inv_gap;
  int   hold_left;
  int   accepted_cnt;
  int   n_items;
  bit   held;
  bit   calm;
  bit   failed;

  matrix3x3_inverse DUT (
    .clk(clk),
    .rst(rst),
    .mat_valid(mat_valid),
    .mat_stall(mat_stall),
    .mat(mat),
    .inv_valid(inv_valid),
    .inv_stall(inv_stall),
    .inv(inv)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic wide_t cross_diff(wide_t a, wide_t b, wide_t c, wide_t d);
    return a * b - c * d;
  endfunction

  // exact quotient cof * 2^(2F) / det, rounded half away from zero, saturated
  function automatic logic [WORD_BITS-1:0] quotient_elem(wide_t cof, wide_t det);
    logic [255:0] mag_n;
    logic [255:0] mag_d;
    logic [255:0] q;
    logic [255:0] limit;
    bit neg;
    neg = (cof < 0) != (det < 0);
    mag_n = (cof < 0) ? -cof : cof;
    mag_d = (det < 0) ? -det : det;
    mag_n = ((mag_n << (2 * FRAC_BITS)) << 1) + mag_d;
    q = mag_n / (mag_d << 1);
    limit = neg ? (256'd1 << (WORD_BITS - 1)) : ((256'd1 << (WORD_BITS - 1)) - 1);
    if (q > limit) q = limit;
    if (neg) q = -q;
    return q[WORD_BITS-1:0];
  endfunction

  function automatic inv_t invert_matrix(mat_t m);
    wide_t e[9];
    wide_t cof[9];
    wide_t det;
    inv_t r;
    e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
    e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
    e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
    cof[0] = cross_diff(e[4], e[8], e[7], e[5]);
    cof[1] = cross_diff(e[2], e[7], e[1], e[8]);
    cof[2] = cross_diff(e[1], e[5], e[2], e[4]);
    cof[3] = cross_diff(e[5], e[6], e[3], e[8]);
    cof[4] = cross_diff(e[0], e[8], e[2], e[6]);
    cof[5] = cross_diff(e[3], e[2], e[0], e[5]);
    cof[6] = cross_diff(e[3], e[7], e[6], e[4]);
    cof[7] = cross_diff(e[6], e[1], e[0], e[7]);
    cof[8] = cross_diff(e[0], e[4], e[3], e[1]);
    det = e[0] * cof[0] - e[1] * cross_diff(e[3], e[8], e[5], e[6])
        + e[2] * cross_diff(e[3], e[7], e[4], e[6]);
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++)
        r[1 + (8 - i) * WORD_BITS +: WORD_BITS] = quotient_elem(cof[i], det);
    end
    return r;
  endfunction

  function automatic mat_t make_mat(logic [WORD_BITS-1:0] v[9]);
    mat_t m;
    for (int i = 0; i < 9; i++) m[(8 - i) * WORD_BITS +: WORD_BITS] = v[i];
    return m;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hFFFF_FFFF;
      5: return ONE;
      6: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic mat_t random_mat();
    logic [WORD_BITS-1:0] v[9];
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0, 1, 2: v[i] = $urandom_range(0, 1 << 19) - (1 << 18);
        3, 4:    v[i] = $urandom;
        5:       v[i] = pick_extreme();
        6:       v[i] = ((i % 4 == 0) ? ONE : 0) + $urandom_range(0, 511) - 256;
        default: v[i] = $urandom_range(0, 64) - 32;
      endcase
    end
    // force a singular matrix now and then: copied row, scaled row or zero column
    if (kind >= 7) begin
      k = $urandom_range(0, 2);
      case (k)
        0: for (int c = 0; c < 3; c++) v[6 + c] = v[c];
        1: for (int c = 0; c < 3; c++) v[3 + c] = v[c] * 3;
        default: for (int r = 0; r < 3; r++) v[3 * r + 1] = 0;
      endcase
    end
    return make_mat(v);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (!mat_valid || mat_taken) begin
      if (mat_gap > 0) begin
        mat_gap <= mat_gap - 1;
        mat_valid <= 1'b0;
      end else if (mat_pending.size() > 0) begin
        mat <= mat_pending.pop_front();
        mat_valid <= 1'b1;
        mat_gap <= pick_gap();
      end else begin
        mat_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the pipeline backs up
  always @(negedge clk) begin
    if (rst) begin
      inv_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      inv_stall <= 1'b1;
    end else if (!held && accepted_cnt >= 300 && inv_valid) begin
      hold_left <= 250;
      held <= 1'b1;
      inv_stall <= 1'b1;
    end else if (inv_gap > 0) begin
      inv_gap <= inv_gap - 1;
      inv_stall <= 1'b1;
    end else begin
      inv_stall <= 1'b0;
      inv_gap <= pick_gap();
    end
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
  end

  // monitor: record accepted matrices and check each inverse against the oldest due
  always @(posedge clk) begin
    inv_t want;
    mat_taken <= mat_valid && !mat_stall;
    if (!rst && mat_valid && !mat_stall) begin
      inverse_due.push_back(invert_matrix(mat));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (!rst && inv_valid && !inv_stall) begin
      if (inverse_due.size() == 0) begin
        $display("%0t: unexpected inverse transaction %h", $time, inv);
        failed = 1'b1;
      end else begin
        want = inverse_due.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (inv[1 + (8 - i) * WORD_BITS +: WORD_BITS] !==
              want[1 + (8 - i) * WORD_BITS +: WORD_BITS]) begin
            $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                     want[1 + (8 - i) * WORD_BITS +: WORD_BITS],
                     inv[1 + (8 - i) * WORD_BITS +: WORD_BITS]);
            failed = 1'b1;
          end
        end
        if (inv.singular !== want.singular) begin
          $display("%0t: singular expected %b actual %b", $time, want.singular,
                   inv.singular);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    logic [WORD_BITS-1:0] v[9];
    rst = 1'b1;
    mat_valid = 1'b0;
    mat = '0;
    inv_stall = 1'b0;
    mat_taken = 1'b0;
    mat_gap = 0;
    inv_gap = 0;
    hold_left = 0;
    accepted_cnt = 0;
    n_items = 0;
    held = 1'b0;
    calm = 1'b0;
    failed = 1'b0;

    // identity, zero, all-equal extremes, scaled diagonals, tiny determinant
    v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                  mat_pending.push_back(make_mat(v));
    v = '{default: 0};                                        mat_pending.push_back(make_mat(v));
    v = '{default: 32'h7FFF_FFFF};                            mat_pending.push_back(make_mat(v));
    v = '{default: 32'h8000_0000};                            mat_pending.push_back(make_mat(v));
    v = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
    mat_pending.push_back(make_mat(v));
    v = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
    mat_pending.push_back(make_mat(v));
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                         mat_pending.push_back(make_mat(v));
    v = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                       mat_pending.push_back(make_mat(v));
    v = '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE};       mat_pending.push_back(make_mat(v));
    v = '{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -3 * ONE};      mat_pending.push_back(make_mat(v));
    v = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};                   mat_pending.push_back(make_mat(v));
    v = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
    mat_pending.push_back(make_mat(v));
    v = '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0};
    mat_pending.push_back(make_mat(v));
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 32'hFFFF_FFFF, ONE, 0, 0, 32'h7FFF_FFFF};
    mat_pending.push_back(make_mat(v));
    v = '{32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF};
    mat_pending.push_back(make_mat(v));
    for (int i = 0; i < N_RANDOM; i++) mat_pending.push_back(random_mat());
    n_items = mat_pending.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (accepted_cnt == n_items && inverse_due.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/m3i_pkg.sv
src/m3i_det.sv
src/m3i_lane.sv
src/matrix3x3_inverse.sv
src/m3i_checker.sv
verif/testbench.sv
